// ===== hw/rtl/deq_pkg.sv =====
`default_nettype none

package deq_pkg;

    localparam int VAL_W = 32;
    localparam int CNT_W = 5;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_NOP        = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } err_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    typedef struct packed {
        logic [2:0]              action;
        logic signed [VAL_W-1:0] data_in;
    } req_t;

    typedef struct packed {
        logic [1:0]              error_code;
        logic signed [VAL_W-1:0] front_value;
        logic signed [VAL_W-1:0] rear_value;
        logic [CNT_W-1:0]        entry_count;
        logic                    is_empty_flag;
    } rsp_t;

    // Outcome of one request as decided by the pointer logic.
    typedef struct packed {
        logic       wr_en;
        logic [1:0] error_code;
    } step_t;

endpackage

`default_nettype wire

// ===== hw/rtl/deq_ram.sv =====
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read-first: a read of the address being written returns the old word.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/deq_ptr.sv =====
`default_nettype none

module deq_ptr #(
    parameter int DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic [2:0]                 action,
    output deq_pkg::step_t                  step,
    output logic [$clog2(DEPTH)-1:0]        wr_addr,
    output logic [$clog2(DEPTH)-1:0]        front_addr,
    output logic [$clog2(DEPTH)-1:0]        rear_addr,
    output logic [$clog2(DEPTH+1)-1:0]      count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST   = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTH_W = (AW+1)'(DEPTH);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [CW-1:0] occ_reg;
    logic [CW-1:0] occ_next;
    logic [AW-1:0] head_prev;
    logic [AW-1:0] head_inc;
    logic          full;
    logic          empty;

    // The sum of a ring position and an offset stays below twice the depth.
    function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
        logic [AW:0] r;
        r = (s >= DEPTH_W) ? (s - DEPTH_W) : s;
        return r[AW-1:0];
    endfunction

    assign head_prev = (head_reg == '0) ? LAST : (head_reg - 1'b1);
    assign head_inc  = (head_reg == LAST) ? '0 : (head_reg + 1'b1);
    assign full      = (occ_reg == FULL_CNT);
    assign empty     = (occ_reg == '0);

    always_comb
    begin
        head_next       = head_reg;
        occ_next        = occ_reg;
        step.wr_en      = 1'b0;
        step.error_code = deq_pkg::ERR_OK;
        wr_addr         = wrap((AW+1)'(head_reg) + (AW+1)'(occ_reg));
        if (accept)
        begin
            unique case (action)
                deq_pkg::ACT_PUSH_FRONT:
                begin
                    wr_addr = head_prev;
                    if (full)
                    begin
                        step.error_code = deq_pkg::ERR_FULL;
                    end
                    else
                    begin
                        step.wr_en = 1'b1;
                        head_next  = head_prev;
                        occ_next   = occ_reg + 1'b1;
                    end
                end
                deq_pkg::ACT_PUSH_BACK:
                begin
                    if (full)
                    begin
                        step.error_code = deq_pkg::ERR_FULL;
                    end
                    else
                    begin
                        step.wr_en = 1'b1;
                        occ_next   = occ_reg + 1'b1;
                    end
                end
                deq_pkg::ACT_POP_FRONT:
                begin
                    if (empty)
                    begin
                        step.error_code = deq_pkg::ERR_EMPTY;
                    end
                    else
                    begin
                        head_next = head_inc;
                        occ_next  = occ_reg - 1'b1;
                    end
                end
                deq_pkg::ACT_POP_BACK:
                begin
                    if (empty)
                    begin
                        step.error_code = deq_pkg::ERR_EMPTY;
                    end
                    else
                    begin
                        occ_next = occ_reg - 1'b1;
                    end
                end
                default:
                begin
                    head_next = head_reg;
                end
            endcase
        end
    end

    // Addresses of both ends after this request; meaningless when it leaves the ring empty.
    assign front_addr = head_next;
    assign rear_addr  = wrap((AW+1)'(head_next) + (AW+1)'(occ_next) - 1'b1);
    assign count      = occ_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            occ_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            occ_reg  <= occ_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/double_ended_queue.sv =====
// Channel   | Handshake                 | Payload
// ----------+---------------------------+---------------------------------------------
// request   | start, accepted when !busy | req: action, data_in
// result    | done, one-cycle strobe    | rsp: error_code, front/rear_value, count, empty
//
// Per request, the pointer update, ring write and both end reads are issued at the
// accepting edge, and the registered RAM data is combined in the following cycle
// (ST_READ). The result register and the done register are loaded at the end of that
// cycle; busy is high for one cycle, so a new request can be taken in the cycle the
// previous result is shown.
// Reset clears the head pointer, the fill count and the control; ring contents are not
// cleared, since only occupied entries ever reach the result.
// The receiver cannot stall; each result is presented exactly once.
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  deq_pkg::req_t      req,
    output logic               done,
    output deq_pkg::rsp_t      rsp
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int VAL_W = deq_pkg::VAL_W;
    localparam int CNT_W = deq_pkg::CNT_W;

    deq_pkg::state_t state_reg;
    deq_pkg::state_t state_next;

    logic                  accept;
    logic                  load_rsp;
    deq_pkg::step_t        step;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         front_addr;
    logic [AW-1:0]         rear_addr;
    logic [CW-1:0]         count;
    logic [DATA_WIDTH-1:0] wdata;
    logic [DATA_WIDTH-1:0] rdata_front;
    logic [DATA_WIDTH-1:0] rdata_rear;
    logic [DATA_WIDTH-1:0] front_raw;
    logic [DATA_WIDTH-1:0] rear_raw;
    logic                  ring_empty;

    logic [DATA_WIDTH-1:0] wdata_reg;
    logic                  fwd_front_reg;
    logic                  fwd_rear_reg;
    logic [1:0]            err_reg;
    logic                  done_reg;
    logic                  done_next;
    deq_pkg::rsp_t         rsp_reg;
    deq_pkg::rsp_t         rsp_next;

    assign accept = start && !busy;
    assign wdata  = DATA_WIDTH'($unsigned(req.data_in));

    deq_ptr #(
        .DEPTH (DEPTH)
    ) u_ptr (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .action     (req.action),
        .step       (step),
        .wr_addr    (wr_addr),
        .front_addr (front_addr),
        .rear_addr  (rear_addr),
        .count      (count)
    );

    // Two copies of the ring so that both ends can be read in the same cycle.
    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram_front (
        .clk   (clk),
        .we    (step.wr_en),
        .waddr (wr_addr),
        .wdata (wdata),
        .raddr (front_addr),
        .rdata (rdata_front)
    );

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram_rear (
        .clk   (clk),
        .we    (step.wr_en),
        .waddr (wr_addr),
        .wdata (wdata),
        .raddr (rear_addr),
        .rdata (rdata_rear)
    );

    // The RAM returns the old word when an end is read at the address just written,
    // so the pushed value is forwarded instead.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wdata_reg     <= wdata;
            fwd_front_reg <= step.wr_en && (front_addr == wr_addr);
            fwd_rear_reg  <= step.wr_en && (rear_addr == wr_addr);
            err_reg       <= step.error_code;
        end
    end

    always_comb
    begin
        unique case (state_reg)
            deq_pkg::ST_IDLE:
            begin
                state_next = start ? deq_pkg::ST_READ : deq_pkg::ST_IDLE;
            end
            deq_pkg::ST_READ:
            begin
                state_next = deq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = deq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy     = (state_reg == deq_pkg::ST_READ);
        load_rsp = (state_reg == deq_pkg::ST_READ);
    end

    assign done_next  = load_rsp;
    assign ring_empty = (count == '0);
    assign front_raw  = fwd_front_reg ? wdata_reg : rdata_front;
    assign rear_raw   = fwd_rear_reg ? wdata_reg : rdata_rear;

    always_comb
    begin
        rsp_next.error_code    = err_reg;
        rsp_next.front_value   = ring_empty ? '0 : VAL_W'(front_raw);
        rsp_next.rear_value    = ring_empty ? '0 : VAL_W'(rear_raw);
        rsp_next.entry_count   = CNT_W'(count);
        rsp_next.is_empty_flag = ring_empty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= deq_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_rsp)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted request did not enter the read cycle");

    a_busy_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("read cycle did not produce a result strobe");

    a_done_while_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_empty_values_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.is_empty_flag) |->
            (rsp.front_value == '0 && rsp.rear_value == '0 && rsp.entry_count == '0))
        else $error("empty result carries nonzero values or count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.error_code == deq_pkg::ERR_FULL) |-> (rsp.entry_count == CNT_W'(DEPTH)))
        else $error("push refused as full while the ring was not full");

endmodule

`default_nettype wire

// ===== sim/double_ended_queue_tb.sv =====
`timescale 1ns / 1ps

module double_ended_queue_tb;

    localparam int RING_DEPTH = 16;
    localparam int WORD_W     = 32;

    // Action encodings outside the defined set; the block treats them as no change.
    localparam logic [2:0] ACT_SPARE_5 = 3'd5;
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    localparam logic [WORD_W-1:0] WORD_MAX_POS = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] WORD_MIN_NEG = 32'h8000_0000;
    localparam logic [WORD_W-1:0] WORD_ONES    = 32'hffff_ffff;
    localparam logic [WORD_W-1:0] WORD_ZERO    = 32'h0000_0000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    deq_pkg::req_t req = '0;
    logic done;
    deq_pkg::rsp_t rsp;

    // Shadow copy of the ring, used to predict each result.
    logic [WORD_W-1:0] shadow_ring [RING_DEPTH];
    logic [3:0]        shadow_head = '0;
    int                shadow_fill = 0;

    deq_pkg::rsp_t expected_views[$];
    int            mismatch_count = 0;
    int            sender_idle_pct = 0;

    double_ended_queue #(
        .DEPTH(RING_DEPTH),
        .DATA_WIDTH(WORD_W)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req),
        .done(done),
        .rsp(rsp)
    );

    always #10 clk = ~clk;

    initial
    begin
        #5ms;
        $display("double_ended_queue_tb failed");
        $finish;
    end

    // Applies one request to the shadow ring and returns the view it should produce.
    function automatic deq_pkg::rsp_t advance_deque(deq_pkg::req_t item);
        deq_pkg::rsp_t view;
        logic [3:0]    slot;
        view = '0;
        view.error_code = deq_pkg::ERR_OK;
        case (item.action) inside
            deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_BACK:
            begin
                if (shadow_fill == RING_DEPTH)
                begin
                    view.error_code = deq_pkg::ERR_FULL;
                end
                else if (item.action == deq_pkg::ACT_PUSH_FRONT)
                begin
                    shadow_head = shadow_head - 4'd1;
                    shadow_ring[shadow_head] = item.data_in;
                    shadow_fill++;
                end
                else
                begin
                    slot = shadow_head + 4'(shadow_fill);
                    shadow_ring[slot] = item.data_in;
                    shadow_fill++;
                end
            end
            deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_POP_BACK:
            begin
                if (shadow_fill == 0)
                begin
                    view.error_code = deq_pkg::ERR_EMPTY;
                end
                else
                begin
                    if (item.action == deq_pkg::ACT_POP_FRONT)
                    begin
                        shadow_head = shadow_head + 4'd1;
                    end
                    shadow_fill--;
                end
            end
            default:
            begin
            end
        endcase
        if (shadow_fill != 0)
        begin
            slot = shadow_head + 4'(shadow_fill - 1);
            view.front_value = shadow_ring[shadow_head];
            view.rear_value  = shadow_ring[slot];
        end
        view.entry_count   = 5'(shadow_fill);
        view.is_empty_flag = (shadow_fill == 0);
        return view;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        mismatch_count++;
        $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    endtask

    always @(posedge clk)
    begin : check_results
        deq_pkg::rsp_t want;
        if (rst_n && done)
        begin
            if (expected_views.size() == 0)
            begin
                report_mismatch("result with no request outstanding",
                                WORD_W'(rsp.entry_count), '0);
            end
            else
            begin
                want = expected_views[0];
                expected_views.delete(0);
                if (rsp.error_code !== want.error_code)
                    report_mismatch("error_code", WORD_W'(rsp.error_code),
                                    WORD_W'(want.error_code));
                if (rsp.front_value !== want.front_value)
                    report_mismatch("front_value", rsp.front_value, want.front_value);
                if (rsp.rear_value !== want.rear_value)
                    report_mismatch("rear_value", rsp.rear_value, want.rear_value);
                if (rsp.entry_count !== want.entry_count)
                    report_mismatch("entry_count", WORD_W'(rsp.entry_count),
                                    WORD_W'(want.entry_count));
                if (rsp.is_empty_flag !== want.is_empty_flag)
                    report_mismatch("is_empty_flag", WORD_W'(rsp.is_empty_flag),
                                    WORD_W'(want.is_empty_flag));
            end
        end
    end

    // Holds start until the request is taken; start is left high when no gap follows,
    // so back-to-back requests never lower and raise it in one time step.
    task automatic issue_request(input logic [2:0] act, input logic [WORD_W-1:0] val);
        deq_pkg::req_t item;
        item.action  = act;
        item.data_in = val;
        start <= 1'b1;
        req <= item;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        expected_views.insert(expected_views.size(), advance_deque(item));
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (expected_views.size() != 0 && waited < 50)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_views.size() != 0)
        begin
            report_mismatch("results never delivered", expected_views.size(), '0);
            expected_views.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic test_empty_and_idle_actions();
        issue_request(deq_pkg::ACT_POP_FRONT, WORD_ONES);
        issue_request(deq_pkg::ACT_POP_BACK, WORD_MIN_NEG);
        issue_request(deq_pkg::ACT_NOP, WORD_MAX_POS);
        issue_request(ACT_SPARE_5, WORD_ONES);
        issue_request(ACT_SPARE_6, WORD_ZERO);
        issue_request(ACT_SPARE_7, WORD_MIN_NEG);
    endtask

    task automatic test_fill_with_extremes();
        issue_request(deq_pkg::ACT_PUSH_FRONT, WORD_MAX_POS);
        issue_request(deq_pkg::ACT_PUSH_BACK, WORD_MIN_NEG);
        issue_request(deq_pkg::ACT_PUSH_FRONT, WORD_ONES);
        issue_request(deq_pkg::ACT_PUSH_BACK, WORD_ZERO);
        for (int i = 4; i < RING_DEPTH; i++)
        begin
            issue_request((i % 2 == 0) ? deq_pkg::ACT_PUSH_FRONT : deq_pkg::ACT_PUSH_BACK,
                          $urandom);
        end
    endtask

    task automatic test_push_when_full();
        issue_request(deq_pkg::ACT_PUSH_FRONT, WORD_ONES);
        issue_request(deq_pkg::ACT_PUSH_BACK, WORD_ONES);
        issue_request(deq_pkg::ACT_POP_FRONT, WORD_ZERO);
        issue_request(deq_pkg::ACT_POP_BACK, WORD_ZERO);
    endtask

    // Push-heavy, balanced and pop-heavy stretches drive the ring to full and to
    // empty repeatedly. Idle actions are mixed in but not counted.
    task automatic test_random_traffic(input int item_total, input int idle_pct);
        int                counted;
        int                push_bias;
        logic [2:0]        act;
        logic [WORD_W-1:0] val;
        counted = 0;
        push_bias = 50;
        sender_idle_pct = idle_pct;
        while (counted < item_total)
        begin
            if (counted % 32 == 0)
            begin
                case ($urandom_range(2))
                    0: push_bias = 85;
                    1: push_bias = 50;
                    default: push_bias = 15;
                endcase
            end
            if ($urandom_range(9) == 0)
            begin
                case ($urandom_range(3))
                    0: val = WORD_MAX_POS;
                    1: val = WORD_MIN_NEG;
                    2: val = WORD_ONES;
                    default: val = WORD_ZERO;
                endcase
            end
            else
            begin
                val = $urandom;
            end
            if ($urandom_range(99) < 6)
            begin
                case ($urandom_range(3))
                    0: act = deq_pkg::ACT_NOP;
                    1: act = ACT_SPARE_5;
                    2: act = ACT_SPARE_6;
                    default: act = ACT_SPARE_7;
                endcase
            end
            else
            begin
                if ($urandom_range(99) < push_bias)
                    act = $urandom_range(1) ? deq_pkg::ACT_PUSH_FRONT : deq_pkg::ACT_PUSH_BACK;
                else
                    act = $urandom_range(1) ? deq_pkg::ACT_POP_FRONT : deq_pkg::ACT_POP_BACK;
                counted++;
            end
            issue_request(act, val);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_idle_actions();
        test_fill_with_extremes();
        test_push_when_full();
        wait_for_results();

        test_random_traffic(340, 37);
        wait_for_results();
        test_random_traffic(330, 51);
        wait_for_results();
        test_random_traffic(330, 0);
        wait_for_results();

        if (mismatch_count == 0)
        begin
            $display("double_ended_queue_tb passed");
        end
        else
        begin
            $display("double_ended_queue_tb failed");
        end
        $finish;
    end

endmodule
